// ===== hdl/potts_lattice_energy_core_defines.svh =====
// assertion macros for the potts lattice energy core checker
// expects signals clk and arst_n in the scope where a macro is used
`ifndef POTTS_LATTICE_ENERGY_CORE_DEFINES_SVH
`define POTTS_LATTICE_ENERGY_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define PLE_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ple check failed");

// next-cycle implication, disabled while in reset
`define PLE_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ple check failed");

`endif

// ===== hdl/ple_pkg.sv =====
// shared widths, register indexes and the per-site flag group
// no dependencies
package ple_pkg;

	localparam int SPIN_W     = 8;
	localparam int COUNT_W    = 14;
	localparam int ENERGY_W   = 30;
	localparam int SIDE_W     = 7;
	localparam int COUPLING_W = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	// matches found for one site: up to two horizontal and two vertical
	localparam int MATCH_W    = 3;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SIDE_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COUPLING    = 2'd1;

	localparam logic [SIDE_W-1:0]            SIDE_RESET     = 7'd2;
	localparam logic signed [COUPLING_W-1:0] COUPLING_RESET = 16'sd256;

	// position flags that travel with each site down the cell chain
	typedef struct packed {
		logic restart;
		logic first_row;
		logic last_row;
		logic last_site;
	} site_flags_t;

endpackage

// ===== hdl/ple_if.sv =====
// handshake channels of the potts lattice energy core: spins, results, configuration
// depends on ple_pkg
interface ple_spin_if import ple_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [SPIN_W-1:0] spin;

	modport source (output valid, output spin, input ready);
	modport sink (input valid, input spin, output ready);
endinterface

interface ple_result_if import ple_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [COUNT_W-1:0]         match_count;
	logic signed [ENERGY_W-1:0] energy_value;

	modport source (output valid, output match_count, output energy_value, input ready);
	modport sink (input valid, input match_count, input energy_value, output ready);
endinterface

interface ple_cfg_if import ple_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/ple_head.sv =====
// entry stage: lattice position tracking and horizontal neighbor matches
// depends on ple_pkg
module ple_head import ple_pkg::*; #(
	parameter int MAX_SIDE = 64,
	parameter int COL_W    = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_valid,
	input  logic [SPIN_W-1:0]  in_spin,
	input  logic [SIDE_W-1:0]  side,
	output logic               pkt_valid,
	output logic [SPIN_W-1:0]  pkt_spin,
	output logic [COL_W-1:0]   pkt_col,
	output site_flags_t        pkt_flags,
	output logic [MATCH_W-1:0] pkt_match
);

	localparam int EFF_W = (COL_W + 1 > SIDE_W) ? COL_W + 1 : SIDE_W;
	localparam logic [EFF_W-1:0] MAX_EFF = EFF_W'(MAX_SIDE);

	logic [COL_W-1:0]  col_q;
	logic [COL_W-1:0]  row_q;
	logic [SPIN_W-1:0] start_q;
	logic [SPIN_W-1:0] left_q;

	logic [EFF_W-1:0]  side_ext;
	logic [EFF_W-1:0]  eff;
	logic [EFF_W-1:0]  last_idx;
	logic              restart;
	logic [COL_W-1:0]  c;
	logic [COL_W-1:0]  r;
	logic              at_first_col;
	logic              at_last_col;
	logic              first_row;
	logic              last_row;
	logic              h_left;
	logic              h_wrap;
	logic              take;

	// clamp the side into 1..MAX_SIDE
	always_comb begin
		side_ext = EFF_W'(side);
		if (side_ext == '0) begin
			eff = EFF_W'(1);
		end else if (side_ext > MAX_EFF) begin
			eff = MAX_EFF;
		end else begin
			eff = side_ext;
		end
		last_idx = eff - EFF_W'(1);
	end

	// position of this site, restarting when the side shrank below it
	always_comb begin
		restart      = (EFF_W'(col_q) >= eff) || (EFF_W'(row_q) >= eff);
		c            = restart ? '0 : col_q;
		r            = restart ? '0 : row_q;
		at_first_col = (c == '0);
		at_last_col  = (EFF_W'(c) == last_idx);
		first_row    = (r == '0);
		last_row     = (EFF_W'(r) == last_idx);
		h_left       = !at_first_col && (left_q == in_spin);
		h_wrap       = at_last_col && (at_first_col || (in_spin == start_q));
	end

	assign take = in_valid && adv;

	// position and row state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			start_q <= '0;
			left_q  <= '0;
		end else if (take) begin
			left_q <= in_spin;
			if (at_first_col) begin
				start_q <= in_spin;
			end
			if (at_last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : r + COL_W'(1);
			end else begin
				col_q <= c + COL_W'(1);
				row_q <= r;
			end
		end
	end

	// packet register feeding the first cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_valid <= 1'b0;
		end else if (adv) begin
			pkt_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pkt_spin            <= in_spin;
			pkt_col             <= c;
			pkt_flags.restart   <= restart;
			pkt_flags.first_row <= first_row;
			pkt_flags.last_row  <= last_row;
			pkt_flags.last_site <= at_last_col && last_row;
			pkt_match           <= MATCH_W'(h_left) + MATCH_W'(h_wrap);
		end
	end

endmodule

// ===== hdl/ple_cell.sv =====
// one column cell: holds the first-row and previous-row spin of its column
// and adds the vertical matches of the site that passes with its column; depends on ple_pkg
module ple_cell import ple_pkg::*; #(
	parameter int COL_W = 6,
	parameter int INDEX = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_valid,
	input  logic [SPIN_W-1:0]  in_spin,
	input  logic [COL_W-1:0]   in_col,
	input  site_flags_t        in_flags,
	input  logic [MATCH_W-1:0] in_match,
	output logic               out_valid,
	output logic [SPIN_W-1:0]  out_spin,
	output logic [COL_W-1:0]   out_col,
	output site_flags_t        out_flags,
	output logic [MATCH_W-1:0] out_match
);

	logic [SPIN_W-1:0]  first_q;
	logic [SPIN_W-1:0]  prev_q;
	logic               hit;
	logic               v_down;
	logic               v_up;
	logic [MATCH_W-1:0] match_nxt;

	// compare against the stored column entries
	always_comb begin
		hit       = in_valid && (in_col == COL_W'(INDEX));
		v_down    = !in_flags.first_row && (prev_q == in_spin);
		v_up      = in_flags.last_row && (in_flags.first_row || (in_spin == first_q));
		match_nxt = hit ? in_match + MATCH_W'(v_down) + MATCH_W'(v_up) : in_match;
	end

	// column storage, written only by its own column
	always_ff @(posedge clk) begin
		if (adv && hit) begin
			prev_q <= in_spin;
			if (in_flags.first_row) begin
				first_q <= in_spin;
			end
		end
	end

	// hand the site on to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_spin  <= in_spin;
			out_col   <= in_col;
			out_flags <= in_flags;
			out_match <= match_nxt;
		end
	end

endmodule

// ===== hdl/ple_tail.sv =====
// end of the chain: saturating pair count, energy product and result register
// depends on ple_pkg and ple_if
module ple_tail import ple_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  site_flags_t                  in_flags,
	input  logic [MATCH_W-1:0]           in_match,
	input  logic signed [COUPLING_W-1:0] coupling,
	output logic                         ready,
	ple_result_if.source                 results
);

	logic [COUNT_W-1:0]                count_q;
	logic                              valid_s1;
	logic [COUNT_W-1:0]                count_s1;
	logic                              out_valid_q;
	logic [COUNT_W-1:0]                match_q;
	logic signed [ENERGY_W-1:0]        energy_q;

	logic                              out_go;
	logic                              take;
	logic                              last;
	logic [COUNT_W-1:0]                base;
	logic [COUNT_W:0]                  sum;
	logic [COUNT_W-1:0]                total;
	logic signed [COUNT_W:0]           cnt_sx;
	logic signed [COUPLING_W+COUNT_W:0] prod;
	logic signed [COUPLING_W+COUNT_W:0] neg;

	// flow control: only a finishing site waits for room in the result stages
	always_comb begin
		out_go = !out_valid_q || results.ready;
		last   = in_valid && in_flags.last_site;
		ready  = !last || !valid_s1 || out_go;
		take   = in_valid && ready;
	end

	// saturating count update
	always_comb begin
		base  = in_flags.restart ? '0 : count_q;
		sum   = {1'b0, base} + (COUNT_W + 1)'(in_match);
		total = (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[COUNT_W-1:0];
	end

	// energy = -coupling * count
	always_comb begin
		cnt_sx = signed'({1'b0, count_s1});
		prod   = coupling * cnt_sx;
		neg    = -prod;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				count_q <= last ? '0 : total;
			end
			if (take && last) begin
				valid_s1 <= 1'b1;
			end else if (out_go) begin
				valid_s1 <= 1'b0;
			end
			if (out_go) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (take && last) begin
			count_s1 <= total;
		end
		if (out_go && valid_s1) begin
			match_q  <= count_s1;
			energy_q <= neg[ENERGY_W-1:0];
		end
	end

	assign results.valid        = out_valid_q;
	assign results.match_count  = match_q;
	assign results.energy_value = energy_q;

endmodule

// ===== hdl/potts_lattice_energy_core.sv =====
// potts model energy of a periodic square lattice, top level
// depends on ple_pkg, ple_if, ple_head, ple_cell, ple_tail
//
//   channel   role     payload                          transaction when
//   spins     sink     spin[7:0]                        valid && ready
//   results   source   match_count[13:0], energy_value  valid && ready
//   cfg       sink     index[1:0], data[15:0]           valid && ready (ready always high)
//
// one spin per cycle while spins.ready is high; the result of a lattice is registered after its last
// site passes the head packet register, the row of MAX_SIDE column cells and the skid stage.
// arst_n clears position, count and all valid bits; the column stores are not cleared.
// spins.ready drops only while a finishing site meets a full result register and skid stage.
module potts_lattice_energy_core import ple_pkg::*; #(
	parameter int MAX_SIDE = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	ple_spin_if.sink     spins,
	ple_result_if.source results,
	ple_cfg_if.sink      cfg
);

	localparam int COL_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

	logic [SIDE_W-1:0]            side_q;
	logic signed [COUPLING_W-1:0] coupling_q;
	logic                         adv;

	logic               ch_valid [0:MAX_SIDE];
	logic [SPIN_W-1:0]  ch_spin  [0:MAX_SIDE];
	logic [COL_W-1:0]   ch_col   [0:MAX_SIDE];
	site_flags_t        ch_flags [0:MAX_SIDE];
	logic [MATCH_W-1:0] ch_match [0:MAX_SIDE];

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q     <= SIDE_RESET;
			coupling_q <= COUPLING_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_SIDE_LENGTH: side_q     <= cfg.data[SIDE_W-1:0];
				REG_COUPLING:    coupling_q <= signed'(cfg.data);
				default: ;
			endcase
		end
	end

	assign spins.ready = adv;

	// entry stage
	ple_head #(
		.MAX_SIDE (MAX_SIDE),
		.COL_W    (COL_W)
	) u_head (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (spins.valid),
		.in_spin   (spins.spin),
		.side      (side_q),
		.pkt_valid (ch_valid[0]),
		.pkt_spin  (ch_spin[0]),
		.pkt_col   (ch_col[0]),
		.pkt_flags (ch_flags[0]),
		.pkt_match (ch_match[0])
	);

	// row of column cells
	for (genvar k = 0; k < MAX_SIDE; k++) begin : g_cell
		ple_cell #(
			.COL_W (COL_W),
			.INDEX (k)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.in_valid  (ch_valid[k]),
			.in_spin   (ch_spin[k]),
			.in_col    (ch_col[k]),
			.in_flags  (ch_flags[k]),
			.in_match  (ch_match[k]),
			.out_valid (ch_valid[k+1]),
			.out_spin  (ch_spin[k+1]),
			.out_col   (ch_col[k+1]),
			.out_flags (ch_flags[k+1]),
			.out_match (ch_match[k+1])
		);
	end

	// count, energy and result output
	ple_tail u_tail (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (ch_valid[MAX_SIDE]),
		.in_flags (ch_flags[MAX_SIDE]),
		.in_match (ch_match[MAX_SIDE]),
		.coupling (coupling_q),
		.ready    (adv),
		.results  (results)
	);

endmodule

// ===== hdl/ple_checker.sv =====
// port-level checks for the potts lattice energy core, bound to the top level
// depends on ple_pkg, ple_if and the assertion macro header
`include "potts_lattice_energy_core_defines.svh"

module ple_checker import ple_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	ple_spin_if.sink     spins,
	ple_result_if.source results,
	ple_cfg_if.sink      cfg
);

	// configuration writes are never held off
	`PLE_ASSERT_IMP(a_cfg_ready, cfg.valid, cfg.ready)

	// an offered result stays offered until taken
	`PLE_ASSERT_NEXT(a_result_held, results.valid && !results.ready, results.valid)

	// a lattice with no matching pairs has zero energy
	`PLE_ASSERT_IMP(a_zero_energy, results.valid && (results.match_count == '0), results.energy_value == '0)

	// spin input stalls only behind a blocked result
	`PLE_ASSERT_IMP(a_stall_cause, !spins.ready, results.valid && !results.ready)

endmodule

bind potts_lattice_energy_core ple_checker u_ple_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.spins   (spins),
	.results (results),
	.cfg     (cfg)
);

// ===== sim/potts_lattice_energy_core_test.sv =====
`timescale 1ns / 100ps
// self-checking testbench for potts_lattice_energy_core: spin streams in, energies out
// depends on ple_pkg and the ple_if interfaces; predicts each lattice energy on its own
module potts_lattice_energy_core_test;
	import ple_pkg::*;

	localparam int MAX_SIDE       = 64;
	localparam int DRAIN_CYCLES   = MAX_SIDE + 3 + 12;
	localparam int RUN_LIMIT      = 400000;
	localparam int RANDOM_SITES   = 330;
	localparam int RANDOM_RESULTS = 20;
	localparam int IDLE_PCT       = 13;
	localparam int REPORT_CAP     = 100;

	// indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

	typedef logic [SPIN_W-1:0] spin_t;

	typedef struct packed {
		logic [COUNT_W-1:0]         match_count;
		logic signed [ENERGY_W-1:0] energy_value;
	} lattice_result_t;

	typedef enum int {SPINS_NEAR, SPINS_FEW, SPINS_ANY, SPINS_RAILS} spin_mix_e;

	// lattice energy predictor and the queue of energies still owed by the block
	class energy_tally;
		spin_t                        top_row [MAX_SIDE];
		spin_t                        prev_row [MAX_SIDE];
		spin_t                        row_head;
		spin_t                        west_spin;
		int unsigned                  col;
		int unsigned                  row;
		logic [COUNT_W-1:0]           pairs;
		logic [SIDE_W-1:0]            side_reg;
		logic signed [COUPLING_W-1:0] coupling_reg;
		lattice_result_t              due_results[$];
		int unsigned                  predicted;
		int unsigned                  errors;

		function new();
			foreach (top_row[i]) begin
				top_row[i] = '0;
				prev_row[i] = '0;
			end
			row_head = '0;
			west_spin = '0;
			col = 0;
			row = 0;
			pairs = '0;
			side_reg = SIDE_RESET;
			coupling_reg = COUPLING_RESET;
			predicted = 0;
			errors = 0;
		endfunction

		task report(input string msg);
			if (errors < REPORT_CAP)
				$display("%0t mismatch: %s", $realtime, msg);
			errors++;
		endtask

		function void set_reg(input logic [CFG_IDX_W-1:0] idx,
				input logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_SIDE_LENGTH: side_reg = data[SIDE_W-1:0];
				REG_COUPLING:    coupling_reg = data;
				default: ;
			endcase
		endfunction

		// zero acts as one, anything past the store depth acts as the depth
		function int unsigned live_side();
			int unsigned n;
			n = 32'(side_reg);
			if (n == 0) n = 1;
			if (n > MAX_SIDE) n = MAX_SIDE;
			return n;
		endfunction

		function int unsigned sites_to_finish();
			int unsigned n;
			n = live_side();
			if (col >= n || row >= n) return n * n;
			return n * n - (row * n + col);
		endfunction

		function void bump(input bit same);
			if (same && pairs != COUNT_MAX) pairs++;
		endfunction

		// fold one accepted spin into the running pair count
		function void take_spin(input spin_t s);
			int unsigned     n;
			longint          product;
			lattice_result_t res;
			n = live_side();
			if (col >= n || row >= n) begin
				col = 0;
				row = 0;
				pairs = '0;
			end
			// right neighbour, wrapping to the row head
			if (col == 0) row_head = s;
			else bump(west_spin == s);
			if (col == n - 1) bump(s == row_head);
			west_spin = s;
			// lower neighbour, wrapping to the first row
			if (row == 0) top_row[col] = s;
			else bump(prev_row[col] == s);
			if (row == n - 1) bump(s == top_row[col]);
			prev_row[col] = s;
			// advance raster position, emit on the last site
			if (col == n - 1) begin
				col = 0;
				if (row == n - 1) begin
					product = -(longint'(coupling_reg) * longint'(pairs));
					res.match_count = pairs;
					res.energy_value = product[ENERGY_W-1:0];
					due_results.push_back(res);
					predicted++;
					row = 0;
					pairs = '0;
				end else begin
					row++;
				end
			end else begin
				col++;
			end
		endfunction

		task check_result(input logic [COUNT_W-1:0] cnt,
				input logic signed [ENERGY_W-1:0] energy);
			lattice_result_t want;
			if (due_results.size() == 0) begin
				report($sformatf("result %0d/%0d with nothing expected", cnt, energy));
				return;
			end
			want = due_results.pop_front();
			if (cnt !== want.match_count)
				report($sformatf("match_count got %0d want %0d", cnt, want.match_count));
			if (energy !== want.energy_value)
				report($sformatf("energy_value got %0d want %0d", energy,
					want.energy_value));
		endtask
	endclass

	logic clk;
	logic arst_n;
	bit   steady;
	int   sink_hold;
	int   cycle_count;

	energy_tally tally = new();

	ple_spin_if   spins();
	ple_result_if results();
	ple_cfg_if    cfg();

	potts_lattice_energy_core #(
		.MAX_SIDE(MAX_SIDE)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.spins  (spins),
		.results(results),
		.cfg    (cfg)
	);

	// clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// result sink: random stalls, long hold-off on request
	initial begin
		sink_hold = 0;
		forever begin
			@(posedge clk);
			if (sink_hold > 0) begin
				results.ready <= 1'b0;
				sink_hold--;
			end else begin
				results.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// compare every result transaction
	always @(posedge clk) begin
		if (arst_n === 1'b1 && results.valid === 1'b1 && results.ready === 1'b1)
			tally.check_result(results.match_count, results.energy_value);
	end

	// one spin transaction, with an occasional idle cycle ahead of it
	task automatic send_spin(input spin_t s);
		int gap;
		gap = (!steady && $urandom_range(99) < IDLE_PCT) ? 1 : 0;
		if (gap > 0) begin
			spins.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		spins.valid <= 1'b1;
		spins.spin <= s;
		@(posedge clk);
		while (!spins.ready) @(posedge clk);
		tally.take_spin(s);
	endtask

	// stop sending, wait for every owed energy, then let the cell row empty
	task automatic settle();
		spins.valid <= 1'b0;
		while (tally.due_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= data;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		tally.set_reg(idx, data);
	endtask

	// register writes only once the block has gone quiet
	task automatic configure(input logic [CFG_DATA_W-1:0] side_data,
			input logic [CFG_DATA_W-1:0] coupling_data);
		settle();
		write_reg(REG_SIDE_LENGTH, side_data);
		write_reg(REG_COUPLING, coupling_data);
		if ($urandom_range(3) == 0)
			write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO,
				CFG_DATA_W'($urandom));
		cfg.valid <= 1'b0;
	endtask

	function automatic spin_t pick_spin(input spin_mix_e mix, input spin_t base);
		case (mix)
			SPINS_NEAR: return base ^ spin_t'($urandom_range(1));
			SPINS_FEW:  return base + spin_t'($urandom_range(3));
			SPINS_ANY:  return spin_t'($urandom);
			default:    return $urandom_range(1) ? 8'hFF : 8'h00;
		endcase
	endfunction

	initial begin : stimulus
		spin_t           d_plain [4]  = '{8'h00, 8'h00, 8'h00, 8'h00};
		spin_t           d_single [2] = '{8'hFF, 8'h00};
		spin_t           d_pair [4]   = '{8'hFF, 8'h00, 8'h00, 8'hFF};
		spin_t           d_three [9]  = '{8'h07, 8'h07, 8'h07, 8'h07, 8'h07, 8'h07,
			8'h03, 8'h03, 8'h80};
		spin_t           d_zero [2]   = '{8'h5A, 8'hA5};
		int unsigned     random_sent;
		int unsigned     n;
		int unsigned     sites;
		int unsigned     pick;
		logic [SIDE_W-1:0] side;
		logic [CFG_DATA_W-1:0] coupling_data;
		spin_mix_e       mix;
		spin_t           base;

		spins.valid <= 1'b0;
		spins.spin <= '0;
		results.ready <= 1'b0;
		cfg.valid <= 1'b0;
		cfg.index <= REG_SIDE_LENGTH;
		cfg.data <= '0;
		steady = 1'b0;
		random_sent = 0;
		arst_n <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers: side two, coupling 256
		foreach (d_plain[i]) send_spin(d_plain[i]);
		// side one, largest positive coupling
		configure(16'h0001, 16'h7FFF);
		foreach (d_single[i]) send_spin(d_single[i]);
		// side two, most negative coupling
		configure(16'hFF02, 16'h8000);
		foreach (d_pair[i]) send_spin(d_pair[i]);
		// side three, zero coupling
		configure(16'h0003, 16'h0000);
		foreach (d_three[i]) send_spin(d_three[i]);
		// side zero acts as one
		configure(16'h0080, 16'h0001);
		foreach (d_zero[i]) send_spin(d_zero[i]);

		// two full rows at an oversized side with no idling: every row store
		// entry gets written, the lattice is left open and restarts on the next side
		steady = 1'b1;
		configure(16'hFFFF, 16'h8000);
		repeat (2 * MAX_SIDE) send_spin(8'hC3);
		steady = 1'b0;

		// result sink holds off while one-site lattices pile up
		configure(16'h0001, 16'h0100);
		sink_hold = 500;
		repeat (120) send_spin(spin_t'($urandom));

		// random phases; register writes may land mid-lattice
		while (random_sent < RANDOM_SITES || tally.predicted < RANDOM_RESULTS) begin
			steady = ($urandom_range(99) < 8);
			pick = $urandom_range(99);
			if (pick < 60) side = SIDE_W'($urandom_range(1, 6));
			else if (pick < 80) side = SIDE_W'($urandom_range(7, 12));
			else if (pick < 88) side = '0;
			else side = SIDE_W'($urandom_range(MAX_SIDE, 127));
			pick = $urandom_range(99);
			if (pick < 10) coupling_data = 16'h8000;
			else if (pick < 20) coupling_data = 16'h7FFF;
			else if (pick < 28) coupling_data = 16'h0000;
			else coupling_data = CFG_DATA_W'($urandom);
			configure((CFG_DATA_W'($urandom) & 16'hFF80) | CFG_DATA_W'(side), coupling_data);
			n = tally.live_side();
			mix = spin_mix_e'($urandom_range(3));
			base = spin_t'($urandom);
			if (n == MAX_SIDE) sites = $urandom_range(1, 40);
			else if ($urandom_range(3) != 0)
				sites = tally.sites_to_finish() + n * n * $urandom_range(0, 2);
			else sites = $urandom_range(1, n * n + n);
			repeat (sites) send_spin(pick_spin(mix, base));
			random_sent += sites;
		end
		steady = 1'b0;

		// wind down
		settle();
		if (tally.due_results.size() != 0)
			tally.report("expected results left over");
		if (tally.errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
